/* rtl/core/acs_pkg.sv */
// ----------------------------------------------------------------------------
// acs_pkg
// Shared types and codes of the 8-bit accumulator CPU step block: operation
// codes of an input word, opcode bytes and the memory request bundle.
// ----------------------------------------------------------------------------
package acs_pkg;

  typedef logic [7:0] byte_t;

  // Operation carried by an input word.
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_STEP  = 2'd2;

  // Instruction opcodes. Every other byte behaves as a one-byte no-op.
  localparam byte_t OPC_NOP = 8'h00;
  localparam byte_t OPC_STA = 8'h10;
  localparam byte_t OPC_LDA = 8'h20;
  localparam byte_t OPC_ADD = 8'h30;
  localparam byte_t OPC_OR  = 8'h40;
  localparam byte_t OPC_AND = 8'h50;
  localparam byte_t OPC_NOT = 8'h60;
  localparam byte_t OPC_JMP = 8'h80;
  localparam byte_t OPC_JN  = 8'h90;
  localparam byte_t OPC_JZ  = 8'hA0;
  localparam byte_t OPC_HLT = 8'hF0;

  // One write port and one read port of the main memory.
  typedef struct packed {
    logic  we;
    byte_t waddr;
    byte_t wdata;
    logic  re;
    byte_t raddr;
  } mem_req_t;

endpackage

/* rtl/core/acs_if.sv */
// ----------------------------------------------------------------------------
// acs_if
// Valid/ready channels of the CPU step block: the request word (memory
// write, memory read or one instruction step) and the response word.
// ----------------------------------------------------------------------------
interface acs_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  acs_pkg::byte_t    address;
  acs_pkg::byte_t    write_data;

  modport source (output valid, output func, output address, output write_data,
                  input ready);
  modport sink (input valid, input func, input address, input write_data,
                output ready);
endinterface

interface acs_rsp_if;
  logic              valid;
  logic              ready;
  acs_pkg::byte_t    read_data;
  acs_pkg::byte_t    accumulator;
  acs_pkg::byte_t    program_counter;
  logic              negative_flag;
  logic              zero_flag;
  logic              halted;
  acs_pkg::byte_t    executed_opcode;

  modport source (output valid, output read_data, output accumulator,
                  output program_counter, output negative_flag, output zero_flag,
                  output halted, output executed_opcode, input ready);
  modport sink (input valid, input read_data, input accumulator,
                input program_counter, input negative_flag, input zero_flag,
                input halted, input executed_opcode, output ready);
endinterface

/* rtl/core/accumulator_cpu_step.sv */
// ----------------------------------------------------------------------------
// accumulator_cpu_step
// 8-bit accumulator CPU with a 256-byte memory, driven one word at a time.
// ----------------------------------------------------------------------------
// Occupancy per word: a write, a read, a step while halted and a one-byte
// instruction end in ST_FIRST; STA and the jumps add ST_ARG; LDA/ADD/OR/AND
// add ST_ARG and ST_DATA. Each state after ST_FIRST is one dependent read of
// the single memory read port. The next word is taken in the cycle the
// current one completes; the response is registered, so it shows in the
// cycle after completion. Reset clears AC, PC, flags and halt, and marks
// every memory byte unwritten (reads as zero) at once: no clearing pass.
// ----------------------------------------------------------------------------
module accumulator_cpu_step (
  input  logic    clk,
  input  logic    rst,
  acs_req_if.sink req,
  acs_rsp_if.source rsp
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FIRST = 2'd1;
  localparam logic [1:0] ST_ARG   = 2'd2;
  localparam logic [1:0] ST_DATA  = 2'd3;

  logic [1:0]        state, state_next;
  logic [1:0]        item_func;
  acs_pkg::byte_t    item_addr, item_wdata;
  acs_pkg::byte_t    op;

  acs_pkg::byte_t    ac, ac_new, ac_next;
  acs_pkg::byte_t    pc, pc_new, pc_next;
  logic              n, z, halt, halt_new;
  logic              n_next, z_next, halt_next;
  logic              upd_flags;

  acs_pkg::mem_req_t mem_req;
  acs_pkg::byte_t    rd_data;

  logic              done, finish, out_free, accept;
  acs_pkg::byte_t    res_rdata, res_opcode;
  acs_pkg::byte_t    pc_p1, pc_p2;

  acs_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  assign pc_p1    = 8'(pc + 8'd1);
  assign pc_p2    = 8'(pc + 8'd2);
  assign out_free = !rsp.valid || rsp.ready;

  // Work out the effect of the word in flight, then commit it only when the
  // response register can take the result.
  always_comb begin
    done       = 1'b0;
    ac_new     = ac;
    pc_new     = pc;
    halt_new   = halt;
    upd_flags  = 1'b0;
    res_rdata  = '0;
    res_opcode = '0;
    state_next = state;
    mem_req    = '0;

    case (state)
      ST_FIRST: begin
        case (item_func)
          acs_pkg::FUNC_WRITE: begin
            done          = 1'b1;
            mem_req.waddr = item_addr;
            mem_req.wdata = item_wdata;
            mem_req.we    = out_free;
          end
          acs_pkg::FUNC_READ: begin
            done      = 1'b1;
            res_rdata = rd_data;
          end
          acs_pkg::FUNC_STEP: begin
            if (halt) begin
              done = 1'b1;
            end else begin
              res_opcode = rd_data;
              case (rd_data)
                acs_pkg::OPC_STA, acs_pkg::OPC_LDA, acs_pkg::OPC_ADD,
                acs_pkg::OPC_OR, acs_pkg::OPC_AND, acs_pkg::OPC_JMP,
                acs_pkg::OPC_JN, acs_pkg::OPC_JZ: begin
                  mem_req.re    = 1'b1;
                  mem_req.raddr = pc_p1;
                  state_next    = ST_ARG;
                end
                acs_pkg::OPC_NOT: begin
                  done      = 1'b1;
                  upd_flags = 1'b1;
                  ac_new    = ~ac;
                  pc_new    = pc_p1;
                end
                acs_pkg::OPC_HLT: begin
                  done      = 1'b1;
                  upd_flags = 1'b1;
                  halt_new  = 1'b1;
                end
                default: begin
                  done      = 1'b1;
                  upd_flags = 1'b1;
                  pc_new    = pc_p1;
                end
              endcase
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end
      ST_ARG: begin
        res_opcode = op;
        case (op)
          acs_pkg::OPC_JMP: begin
            done      = 1'b1;
            upd_flags = 1'b1;
            pc_new    = rd_data;
          end
          acs_pkg::OPC_JN: begin
            done      = 1'b1;
            upd_flags = 1'b1;
            pc_new    = n ? rd_data : pc_p2;
          end
          acs_pkg::OPC_JZ: begin
            done      = 1'b1;
            upd_flags = 1'b1;
            pc_new    = z ? rd_data : pc_p2;
          end
          acs_pkg::OPC_STA: begin
            done          = 1'b1;
            upd_flags     = 1'b1;
            pc_new        = pc_p2;
            mem_req.waddr = rd_data;
            mem_req.wdata = ac;
            mem_req.we    = out_free;
          end
          default: begin
            mem_req.re    = 1'b1;
            mem_req.raddr = rd_data;
            state_next    = ST_DATA;
          end
        endcase
      end
      ST_DATA: begin
        res_opcode = op;
        done       = 1'b1;
        upd_flags  = 1'b1;
        pc_new     = pc_p2;
        case (op)
          acs_pkg::OPC_LDA: ac_new = rd_data;
          acs_pkg::OPC_ADD: ac_new = 8'(ac + rd_data);
          acs_pkg::OPC_OR:  ac_new = ac | rd_data;
          acs_pkg::OPC_AND: ac_new = ac & rd_data;
          default:          ac_new = ac;
        endcase
      end
      default: begin
      end
    endcase

    finish    = done && out_free;
    ac_next   = finish ? ac_new : ac;
    pc_next   = finish ? pc_new : pc;
    halt_next = finish ? halt_new : halt;
    n_next    = (finish && upd_flags) ? ac_new[7] : n;
    z_next    = (finish && upd_flags) ? (ac_new == 8'd0) : z;

    req.ready = (state == ST_IDLE) || finish;
    accept    = req.valid && req.ready;

    // A new word issues its first read in the cycle the previous one ends,
    // against the PC that word leaves behind, or at its own address for a read.
    if (accept) begin
      mem_req.re    = 1'b1;
      mem_req.raddr = (req.func == acs_pkg::FUNC_READ) ? req.address : pc_next;
      state_next    = ST_FIRST;
    end else if (finish) begin
      state_next = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ac    <= '0;
      pc    <= '0;
      n     <= 1'b0;
      z     <= 1'b0;
      halt  <= 1'b0;
    end else begin
      state <= state_next;
      ac    <= ac_next;
      pc    <= pc_next;
      n     <= n_next;
      z     <= z_next;
      halt  <= halt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_func  <= req.func;
      item_addr  <= req.address;
      item_wdata <= req.write_data;
    end
    if (state == ST_FIRST) begin
      op <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (finish) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      rsp.read_data       <= res_rdata;
      rsp.accumulator     <= ac_next;
      rsp.program_counter <= pc_next;
      rsp.negative_flag   <= n_next;
      rsp.zero_flag       <= z_next;
      rsp.halted          <= halt_next;
      rsp.executed_opcode <= res_opcode;
    end
  end

`ifndef SYNTHESIS
  // Once halted, only reset brings the machine back.
  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    halt |=> halt) else $error("halt flag dropped without reset");

  // A halted machine leaves PC and AC alone.
  a_halt_frozen: assert property (@(posedge clk) disable iff (rst)
    halt |=> ($stable(pc) && $stable(ac)))
    else $error("PC or AC changed while halted");

  // Memory is written only by a word that completes in this cycle.
  a_write_on_finish: assert property (@(posedge clk) disable iff (rst)
    mem_req.we |-> (finish && ((state == ST_FIRST) || (state == ST_ARG))))
    else $error("memory write outside a completing word");

  // The operand address byte is captured only after an opcode fetch.
  a_arg_after_first: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ARG) |-> ($past(state) == ST_FIRST) || ($past(state) == ST_ARG))
    else $error("operand state entered out of order");
`endif

endmodule

/* rtl/core/acs_mem.sv */
// ----------------------------------------------------------------------------
// acs_mem
// 256-byte main memory with one write and one registered read port. Bytes
// that were never written since reset read as zero; a read of the byte being
// written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module acs_mem (
  input  logic              clk,
  input  logic              rst,
  input  acs_pkg::mem_req_t req,
  output acs_pkg::byte_t    rd_data
);

  acs_pkg::byte_t mem [256];
  logic [255:0]   written;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (req.we) begin
      written[req.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      if (req.we && (req.waddr == req.raddr)) begin
        rd_data <= req.wdata;
      end else if (written[req.raddr]) begin
        rd_data <= mem[req.raddr];
      end else begin
        rd_data <= '0;
      end
    end
  end

endmodule
